FILE: hw/rtl/das_pkg.sv
package das_pkg;

	// List capacity and field widths
	localparam int unsigned MAX_ITEMS  = 32;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned POS_W      = 5;
	localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Flipping the sign bit makes unsigned order equal signed order
	localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

	// One classified item on its way from front to back
	typedef struct packed {
		logic [VAL_W-1:0] key;
		logic [POS_W-1:0] pos;
		logic             store;
		logic             last;
	} q_entry_t;

	// Write side of the queue
	typedef struct packed {
		logic     en;
		q_entry_t entry;
	} q_wr_t;

	// Read side of the queue
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_rd_t;

	// Back-end control states
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} back_state_t;

endpackage

FILE: hw/rtl/das_item_if.sv
interface das_item_if;
	import das_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    last_in;

	modport source (output valid, value, last_in, input ready);
	modport sink (input valid, value, last_in, output ready);
endinterface

FILE: hw/rtl/das_result_if.sv
interface das_result_if;
	import das_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             last_out;
	logic             overflow;

	modport source (output valid, position, last_out, overflow, input ready);
	modport sink (input valid, position, last_out, overflow, output ready);
endinterface

FILE: hw/rtl/das_front.sv
module das_front
	import das_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	das_item_if.sink     item,
	input  logic         q_full,
	output q_wr_t        q_wr
);

	logic [CNT_W-1:0] cnt_q;
	logic             take;

	assign item.ready = !q_full;
	assign take       = item.valid && item.ready;

	// Classify: store while room is left, otherwise mark for drop
	always_comb begin
		q_wr.en          = take;
		q_wr.entry.key   = item.value ^ SIGN_FLIP;
		q_wr.entry.pos   = POS_W'(cnt_q);
		q_wr.entry.store = (cnt_q < CNT_W'(MAX_ITEMS));
		q_wr.entry.last  = item.last_in;
	end

	// Track position within the current list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (item.last_in) begin
				cnt_q <= '0;
			end else if (cnt_q < CNT_W'(MAX_ITEMS)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/das_queue.sv
module das_queue
	import das_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t q_wr,
	input  logic  pop,
	output logic  q_full,
	output q_rd_t q_rd
);

	q_entry_t          mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign q_full      = (cnt_q == FCNT_W'(FIFO_DEPTH));
	assign q_rd.valid  = (cnt_q != '0);
	assign q_rd.entry  = mem_q[rd_ptr_q];
	assign do_pop      = pop && q_rd.valid;

	// Store incoming transaction
	always_ff @(posedge clk) begin
		if (q_wr.en) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.en) begin
				wr_ptr_q <= (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FPTR_W'(1);
			end
			if (q_wr.en && !do_pop) begin
				cnt_q <= cnt_q + FCNT_W'(1);
			end else if (do_pop && !q_wr.en) begin
				cnt_q <= cnt_q - FCNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/das_back.sv
module das_back
	import das_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  q_rd_t         q_rd,
	output logic          pop,
	das_result_if.source  result
);

	logic [VAL_W-1:0] key_q [MAX_ITEMS];
	logic [POS_W-1:0] pos_q [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] gt;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	back_state_t      state_q, state_d;
	logic             insert, shift, load_out, out_last;
	logic             out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q, out_ovf_q;

	assign out_last = (cnt_q == CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (q_rd.valid && q_rd.entry.last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_out && out_last) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Control outputs
	always_comb begin
		pop      = 1'b0;
		insert   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				pop    = q_rd.valid;
				insert = q_rd.valid && q_rd.entry.store;
			end
			ST_EMIT: begin
				load_out = !out_valid_q || result.ready;
			end
			default: ;
		endcase
		shift = load_out;
	end

	// Compare new key against every cell; empty cells lose
	always_comb begin
		for (int k = 0; k < MAX_ITEMS; k++) begin
			gt[k] = (CNT_W'(k) >= cnt_q) || (q_rd.entry.key > key_q[k]);
		end
	end

	// Sorted cell chain: insert after equal keys, shift toward head on emit
	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		always_ff @(posedge clk) begin
			if (insert) begin
				if (k == 0) begin
					if (gt[k]) begin
						key_q[k] <= q_rd.entry.key;
						pos_q[k] <= q_rd.entry.pos;
					end
				end else begin
					if (gt[k] && !gt[(k == 0) ? 0 : k - 1]) begin
						key_q[k] <= q_rd.entry.key;
						pos_q[k] <= q_rd.entry.pos;
					end else if (gt[k]) begin
						key_q[k] <= key_q[(k == 0) ? 0 : k - 1];
						pos_q[k] <= pos_q[(k == 0) ? 0 : k - 1];
					end
				end
			end else if (shift && (k < MAX_ITEMS - 1)) begin
				key_q[k] <= key_q[(k < MAX_ITEMS - 1) ? k + 1 : k];
				pos_q[k] <= pos_q[(k < MAX_ITEMS - 1) ? k + 1 : k];
			end
		end
	end

	// Control registers: state, fill count, overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (shift) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (pop && !q_rd.entry.store) begin
				ovf_q <= 1'b1;
			end else if (load_out && out_last) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pos_q  <= pos_q[0];
			out_last_q <= out_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.position = out_pos_q;
	assign result.last_out = out_last_q;
	assign result.overflow = out_ovf_q;

endmodule

FILE: hw/rtl/descending_argsort.sv
// The first position leaves once the marked item has passed the queue, the
// sorted cell chain, the emit state and the output register; then one result per
// cycle while the sink keeps ready high. Throughput: one value per cycle while a
// list loads into the sorted cell chain; while a list is emitted, input stalls
// once the two-entry queue is full. Reset: arst_n clears all control state at once;
// stored values carry no reset and are never read before they are written.
module descending_argsort
	import das_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	das_item_if.sink     item,
	das_result_if.source result
);

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	das_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	das_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_full (q_full),
		.q_rd   (q_rd)
	);

	das_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.pop    (pop),
		.result (result)
	);

endmodule
